@@ design/usbcd_pkg.sv @@
`default_nettype none

package usbcd_pkg;

  localparam logic [7:0] DirInBit   = 8'h80;
  localparam logic [7:0] EpNumMask  = 8'h0F;
  localparam logic [7:0] AttrMask   = 8'h03;
  localparam logic [7:0] AttrBulk   = 8'h02;
  localparam logic [7:0] TypeIface  = 8'd4;
  localparam logic [7:0] TypeEp     = 8'd5;

  localparam logic [7:0] MatchClassRst    = 8'd8;
  localparam logic [7:0] MatchSubclassRst = 8'd6;
  localparam logic [7:0] MatchProtocolRst = 8'd80;

  typedef enum logic [1:0] {
    CFG_CLASS    = 2'd0,
    CFG_SUBCLASS = 2'd1,
    CFG_PROTOCOL = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] match_class;
    logic [7:0] match_subclass;
    logic [7:0] match_protocol;
  } cfg_t;

  typedef struct packed {
    logic        scan_status;
    logic [7:0]  iface_number;
    logic [3:0]  in_endpoint;
    logic [15:0] in_packet_max;
    logic [3:0]  out_endpoint;
    logic [15:0] out_packet_max;
  } res_t;

endpackage

`default_nettype wire

@@ design/usbcd_in_if.sv @@
`default_nettype none

interface usbcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] blob_byte;
  logic       last_byte;

  modport source (output valid, output blob_byte, output last_byte, input ready);
  modport sink (input valid, input blob_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ design/usbcd_out_if.sv @@
`default_nettype none

interface usbcd_out_if;
  logic        valid;
  logic        ready;
  logic        scan_status;
  logic [7:0]  iface_number;
  logic [3:0]  in_endpoint;
  logic [15:0] in_packet_max;
  logic [3:0]  out_endpoint;
  logic [15:0] out_packet_max;

  modport source (output valid, output scan_status, output iface_number,
                  output in_endpoint, output in_packet_max, output out_endpoint,
                  output out_packet_max, input ready);
  modport sink (input valid, input scan_status, input iface_number,
                input in_endpoint, input in_packet_max, input out_endpoint,
                input out_packet_max, output ready);
endinterface

`default_nettype wire

@@ design/usbcd_walk.sv @@
`default_nettype none

module usbcd_walk
  import usbcd_pkg::*;
#(
  parameter int unsigned MAX_BLOB_BYTES = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  input  wire cfg_t       cfg_i,
  output res_t            res_o
);

  localparam int unsigned CntW = $clog2(MAX_BLOB_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOB_BYTES);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]  pos_q, pos_d, len_q, len_d, type_q, type_d;
  logic        stop_q, stop_d, scope_q, scope_d;
  logic [1:0]  cmatch_q, cmatch_d;
  logic [7:0]  piface_q, piface_d, addr_q, addr_d, attr_q, attr_d, low_q, low_d;
  logic [7:0]  fiface_q, fiface_d;
  logic [3:0]  in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic [15:0] in_size_q, in_size_d, out_size_q, out_size_d;
  logic [7:0]  pos_inc;

  always_comb begin
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    len_d      = len_q;
    type_d     = type_q;
    stop_d     = stop_q;
    scope_d    = scope_q;
    cmatch_d   = cmatch_q;
    piface_d   = piface_q;
    addr_d     = addr_q;
    attr_d     = attr_q;
    low_d      = low_q;
    fiface_d   = fiface_q;
    in_slot_d  = in_slot_q;
    in_size_d  = in_size_q;
    out_slot_d = out_slot_q;
    out_size_d = out_size_q;
    pos_inc    = pos_q + 8'd1;

    if (cnt_q < CntMax) begin
      cnt_d = cnt_q + CntW'(1);
      if (!stop_q) begin
        if (pos_q == 8'd0) begin
          if (byte_i == 8'd0) begin
            stop_d = 1'b1;
          end else begin
            len_d  = byte_i;
            type_d = 8'd0;
          end
        end else if (pos_q == 8'd1) begin
          type_d = byte_i;
          if (byte_i == TypeIface) begin
            scope_d  = 1'b0;
            cmatch_d = 2'b00;
          end
        end else if (type_q == TypeIface) begin
          if (pos_q == 8'd2) begin
            piface_d = byte_i;
          end else if (pos_q == 8'd5) begin
            cmatch_d[0] = (byte_i == cfg_i.match_class);
          end else if (pos_q == 8'd6) begin
            cmatch_d[1] = (byte_i == cfg_i.match_subclass);
          end else if (pos_q == 8'd7 && cmatch_q == 2'b11 &&
                       byte_i == cfg_i.match_protocol) begin
            scope_d  = 1'b1;
            fiface_d = piface_q;
          end
        end else if (type_q == TypeEp) begin
          if (pos_q == 8'd2) begin
            addr_d = byte_i;
          end else if (pos_q == 8'd3) begin
            attr_d = byte_i;
          end else if (pos_q == 8'd4) begin
            low_d = byte_i;
          end else if (pos_q == 8'd5 && scope_q && (attr_q & AttrMask) == AttrBulk) begin
            if ((addr_q & DirInBit) != 8'd0) begin
              if (in_slot_q == 4'd0) begin
                in_slot_d = addr_q[3:0] & EpNumMask[3:0];
                in_size_d = {byte_i, low_q};
              end
            end else if (out_slot_q == 4'd0) begin
              out_slot_d = addr_q[3:0] & EpNumMask[3:0];
              out_size_d = {byte_i, low_q};
            end
          end
        end
        // A zero length byte stops the walk and leaves the offset alone.
        if (!(pos_q == 8'd0 && byte_i == 8'd0)) begin
          pos_d = (pos_inc >= len_d) ? 8'd0 : pos_inc;
        end
      end
    end

    res_o.scan_status    = (in_slot_d == 4'd0) || (out_slot_d == 4'd0);
    res_o.iface_number   = fiface_d;
    res_o.in_endpoint    = in_slot_d;
    res_o.in_packet_max  = in_size_d;
    res_o.out_endpoint   = out_slot_d;
    res_o.out_packet_max = out_size_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pos_q      <= '0;
      len_q      <= '0;
      type_q     <= '0;
      stop_q     <= 1'b0;
      scope_q    <= 1'b0;
      cmatch_q   <= '0;
      piface_q   <= '0;
      addr_q     <= '0;
      attr_q     <= '0;
      low_q      <= '0;
      fiface_q   <= '0;
      in_slot_q  <= '0;
      in_size_q  <= '0;
      out_slot_q <= '0;
      out_size_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        // The set is complete: start the next one from a clean walk.
        cnt_q      <= '0;
        pos_q      <= '0;
        len_q      <= '0;
        type_q     <= '0;
        stop_q     <= 1'b0;
        scope_q    <= 1'b0;
        cmatch_q   <= '0;
        piface_q   <= '0;
        addr_q     <= '0;
        attr_q     <= '0;
        low_q      <= '0;
        fiface_q   <= '0;
        in_slot_q  <= '0;
        in_size_q  <= '0;
        out_slot_q <= '0;
        out_size_q <= '0;
      end else begin
        cnt_q      <= cnt_d;
        pos_q      <= pos_d;
        len_q      <= len_d;
        type_q     <= type_d;
        stop_q     <= stop_d;
        scope_q    <= scope_d;
        cmatch_q   <= cmatch_d;
        piface_q   <= piface_d;
        addr_q     <= addr_d;
        attr_q     <= attr_d;
        low_q      <= low_d;
        fiface_q   <= fiface_d;
        in_slot_q  <= in_slot_d;
        in_size_q  <= in_size_d;
        out_slot_q <= out_slot_d;
        out_size_q <= out_size_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/usb_config_descriptor_msc_scan.sv @@
// A result is loaded into the output register when the item with last_byte leaves the input
// register, which waits while the output register still holds a result that is not taken.
// Throughput: one byte per cycle unless stalled; the descriptor walk updates its state per byte.
// The only stall comes from a result that waits at the output while the next set ends.
// Reset (rst_ni low, asynchronous) clears the walk state, empties the input and output
// registers, and loads the match registers with class 8, subclass 6 and protocol 80.
`default_nettype none

module usb_config_descriptor_msc_scan
  import usbcd_pkg::*;
#(
  parameter int unsigned MAX_BLOB_BYTES = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  usbcd_in_if.sink        in_if,
  usbcd_out_if.source     out_if
);

  cfg_t       cfg_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_adv;
  logic       out_valid_q;
  res_t       out_q;
  res_t       walk_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_class    <= MatchClassRst;
      cfg_q.match_subclass <= MatchSubclassRst;
      cfg_q.match_protocol <= MatchProtocolRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CLASS:    cfg_q.match_class    <= cfg_data_i;
        CFG_SUBCLASS: cfg_q.match_subclass <= cfg_data_i;
        CFG_PROTOCOL: cfg_q.match_protocol <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Only a closing byte needs room in the output register.
  assign s1_adv      = s1_valid_q && (!s1_last_q || !out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_q <= in_if.blob_byte;
      s1_last_q <= in_if.last_byte;
    end
  end

  usbcd_walk #(
    .MAX_BLOB_BYTES(MAX_BLOB_BYTES)
  ) u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .cfg_i  (cfg_q),
    .res_o  (walk_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_q <= walk_res;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.scan_status    = out_q.scan_status;
  assign out_if.iface_number   = out_q.iface_number;
  assign out_if.in_endpoint    = out_q.in_endpoint;
  assign out_if.in_packet_max  = out_q.in_packet_max;
  assign out_if.out_endpoint   = out_q.out_endpoint;
  assign out_if.out_packet_max = out_q.out_packet_max;

endmodule

`default_nettype wire

@@ design/usbcd_chk.sv @@
`default_nettype none

module usbcd_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        scan_status_i,
  input wire logic [3:0]  in_endpoint_i,
  input wire logic [3:0]  out_endpoint_i,
  input wire logic [15:0] in_packet_max_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_size_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(in_packet_max_i))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> scan_status_i == (in_endpoint_i == 4'd0 || out_endpoint_i == 4'd0))
    else $error("status disagrees with endpoint numbers");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind usb_config_descriptor_msc_scan usbcd_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .scan_status_i   (out_if.scan_status),
  .in_endpoint_i   (out_if.in_endpoint),
  .out_endpoint_i  (out_if.out_endpoint),
  .in_packet_max_i (out_if.in_packet_max)
);

`default_nettype wire
